>>> rtl/msa_pkg.sv
// Shared types and constants of the max-distance slot allocator.
// Holds the controller states, the result select codes and the command and
// status structs that join the controller and the datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package msa_pkg;

    // Fixed field widths of the channels
    localparam int ID_W       = 10;
    localparam int SLOT_OUT_W = 11;
    localparam int LOT_W      = 11;

    // Storage defaults
    localparam int NUM_SLOTS_DEF   = 1024;
    localparam int NUM_CLIENTS_DEF = 1024;

    localparam logic [LOT_W-1:0] LOT_SIZE_RESET = LOT_W'(1024);

    // Request opcode
    localparam logic CMD_LEAVE = 1'b1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOKUP,
        ST_SCAN,
        ST_DRAIN,
        ST_FINAL
    } t_state;

    typedef enum logic [1:0] {
        RES_NONE,
        RES_HELD,
        RES_PICK
    } t_res_sel;

    typedef struct packed {
        logic     clr_en;
        logic     req_ready;
        logic     scan_start;
        logic     scan_issue;
        logic     leave_wr;
        logic     park_wr;
        logic     res_load;
        t_res_sel res_sel;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic req_valid;
        logic is_leave;
        logic id_ok;
        logic held_nz;
        logic scan_last;
        logic pick_nz;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

>>> rtl/msa_if.sv
// Valid/ready channel interfaces of the slot allocator: configuration,
// request and response. Depends on msa_pkg for the field widths.
`timescale 1ns / 1ps
`default_nettype none

interface msa_cfg_if;
    import msa_pkg::*;
    logic             valid;
    logic             ready;
    logic [LOT_W-1:0] lot_size;
    modport source (output valid, output lot_size, input ready);
    modport sink   (input valid, input lot_size, output ready);
endinterface

interface msa_req_if;
    import msa_pkg::*;
    logic            valid;
    logic            ready;
    logic            cmd;
    logic [ID_W-1:0] client_id;
    modport source (output valid, output cmd, output client_id, input ready);
    modport sink   (input valid, input cmd, input client_id, output ready);
endinterface

interface msa_rsp_if;
    import msa_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [SLOT_OUT_W-1:0] slot;
    logic                  lot_full;
    modport source (output valid, output slot, output lot_full, input ready);
    modport sink   (input valid, input slot, input lot_full, output ready);
endinterface

`default_nettype wire

>>> rtl/max_distance_slot_allocator.sv
// Top level of the max-distance slot allocator: controller plus datapath.
// Depends on msa_pkg, msa_if, msa_ctrl and msa_dp.
`timescale 1ns / 1ps
`default_nettype none

// Hands out slots 1..lot_size so that each arriving client sits as far as
// possible from every occupied slot (ties go to the lowest slot), and frees a
// slot when its client leaves. Every request gets exactly one response:
// arrive returns the new slot (or the slot the client already holds, or 0
// with lot_full set when no slot in 1..lot_size is free); leave and ids at
// or above NUM_CLIENTS return slot 0. After reset the block runs a clearing
// pass over both memories, max(NUM_SLOTS, NUM_CLIENTS) entries deep, and
// holds ready low meanwhile (configuration writes are taken throughout).
// A leave, or an arrive of an id already parked, passes the read and lookup
// states and loads its response in lookup once the output register is free.
// An arrive that needs a new slot walks the occupancy memory up to the
// clamped lot size, one slot per cycle through its single read port, then
// loads its response in the final state once the output register is free.
// The request side reopens as soon as a response is loaded into the output
// register, so the next request proceeds while the previous response waits
// for its transfer. lot_size is written through its own channel; the user
// must write it only while the block is idle, which the block does not
// enforce. Zero counts as 1 and values above NUM_SLOTS saturate.

module max_distance_slot_allocator #(
    parameter int NUM_SLOTS   = msa_pkg::NUM_SLOTS_DEF,
    parameter int NUM_CLIENTS = msa_pkg::NUM_CLIENTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    msa_cfg_if.sink   i_cfg,
    msa_req_if.sink   i_req,
    msa_rsp_if.source o_rsp
);
    import msa_pkg::*;

    // Command and status between sequencer and datapath
    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    // Sequencer: clear pass, lookup, scan, result
    msa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd)
    );

    // Memories, gap scan and response register
    msa_dp #(
        .NUM_SLOTS   (NUM_SLOTS),
        .NUM_CLIENTS (NUM_CLIENTS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_req   (i_req),
        .o_rsp   (o_rsp),
        .i_cmd   (dp_cmd),
        .o_stat  (dp_stat)
    );

endmodule

`default_nettype wire

>>> rtl/msa_ctrl.sv
// Controller of the slot allocator: sequences clear, lookup, scan and result.
// Depends on msa_pkg for the state enum and the command/status structs.
`timescale 1ns / 1ps
`default_nettype none

module msa_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  msa_pkg::t_dp_stat  i_stat,
    output msa_pkg::t_dp_cmd   o_cmd
);
    import msa_pkg::*;

    t_state r_state;
    t_state n_state;

    // Arrive of an unparked, valid id needs a scan
    logic need_scan;
    assign need_scan = i_stat.id_ok && !i_stat.is_leave && !i_stat.held_nz;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_stat.req_valid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_LOOKUP;
            end
            ST_LOOKUP: begin
                if (need_scan) begin
                    n_state = ST_SCAN;
                end else if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_SCAN: begin
                if (i_stat.scan_last) n_state = ST_DRAIN;
            end
            ST_DRAIN: begin
                n_state = ST_FINAL;
            end
            ST_FINAL: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    always_comb begin
        o_cmd = '0;
        o_cmd.res_sel = RES_NONE;
        unique case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            ST_IDLE: begin
                o_cmd.req_ready = 1'b1;
            end
            ST_READ: begin
            end
            ST_LOOKUP: begin
                if (need_scan) begin
                    o_cmd.scan_start = 1'b1;
                end else if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.leave_wr = i_stat.id_ok && i_stat.is_leave;
                    if (i_stat.id_ok && !i_stat.is_leave) begin
                        o_cmd.res_sel = RES_HELD;
                    end
                end
            end
            ST_SCAN: begin
                o_cmd.scan_issue = 1'b1;
            end
            ST_DRAIN: begin
            end
            ST_FINAL: begin
                if (i_stat.out_free) begin
                    o_cmd.res_load = 1'b1;
                    o_cmd.res_sel  = RES_PICK;
                    o_cmd.park_wr  = i_stat.pick_nz;
                end
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/msa_dp.sv
// Datapath of the slot allocator: occupancy and client memories, gap scan,
// lot size register and the response register. Depends on msa_pkg, msa_if.
`timescale 1ns / 1ps
`default_nettype none

module msa_dp #(
    parameter int NUM_SLOTS   = msa_pkg::NUM_SLOTS_DEF,
    parameter int NUM_CLIENTS = msa_pkg::NUM_CLIENTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    msa_cfg_if.sink           i_cfg,
    msa_req_if.sink           i_req,
    msa_rsp_if.source         o_rsp,
    input  msa_pkg::t_dp_cmd  i_cmd,
    output msa_pkg::t_dp_stat o_stat
);
    import msa_pkg::*;

    localparam int SLOT_W    = $clog2(NUM_SLOTS + 1);
    localparam int SLOT_AW   = $clog2(NUM_SLOTS);
    localparam int CLI_AW    = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
    localparam int CLR_DEPTH = (NUM_SLOTS > NUM_CLIENTS) ? NUM_SLOTS : NUM_CLIENTS;
    localparam int CLR_W     = $clog2(CLR_DEPTH);

    logic              mem_occ [NUM_SLOTS];
    logic [SLOT_W-1:0] mem_cli [NUM_CLIENTS];

    logic [LOT_W-1:0]      r_lot_size;
    logic                  r_cmd;
    logic [ID_W-1:0]       r_id;
    logic [CLR_W-1:0]      r_clr_cnt;
    logic [SLOT_W-1:0]     r_s;
    logic                  r_rd_vld;
    logic [SLOT_W-1:0]     r_rd_slot;
    logic                  r_occ_rd;
    logic [SLOT_W-1:0]     r_held;
    logic [SLOT_W-1:0]     r_prev;
    logic [SLOT_W-1:0]     r_best;
    logic [SLOT_W-1:0]     r_dist;
    logic                  r_out_valid;
    logic [SLOT_OUT_W-1:0] r_out_slot;
    logic                  r_out_full;

    logic [SLOT_W-1:0]  eff_size;
    logic [CLI_AW-1:0]  id_addr;
    logic [SLOT_W-1:0]  gap;
    logic [SLOT_W-1:0]  half;
    logic [SLOT_W:0]    pair_sum;
    logic [SLOT_W-1:0]  mid;
    logic [SLOT_W-1:0]  first_dist;
    logic [SLOT_W-1:0]  tail;
    logic [SLOT_W-1:0]  pick;
    logic [SLOT_W-1:0]  n_best;
    logic [SLOT_W-1:0]  n_dist;
    logic               occ_we;
    logic [SLOT_AW-1:0] occ_waddr;
    logic               occ_wdata;
    logic               cli_we;
    logic [CLI_AW-1:0]  cli_waddr;
    logic [SLOT_W-1:0]  cli_wdata;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = i_cmd.req_ready;

    // Clamp the lot size to 1..NUM_SLOTS
    always_comb begin
        if (r_lot_size == '0) begin
            eff_size = SLOT_W'(1);
        end else if (32'(r_lot_size) > NUM_SLOTS) begin
            eff_size = SLOT_W'(NUM_SLOTS);
        end else begin
            eff_size = SLOT_W'(r_lot_size);
        end
    end

    assign id_addr = CLI_AW'(r_id);

    // Candidate of the slot whose occupancy just came back from memory
    assign gap        = r_rd_slot - r_prev;
    assign half       = SLOT_W'(gap >> 1);
    assign pair_sum   = {1'b0, r_prev} + {1'b0, r_rd_slot};
    assign mid        = pair_sum[SLOT_W:1];
    assign first_dist = r_rd_slot - SLOT_W'(1);

    always_comb begin
        n_best = r_best;
        n_dist = r_dist;
        if (r_prev == '0) begin
            if (first_dist > r_dist) begin
                n_best = SLOT_W'(1);
                n_dist = first_dist;
            end
        end else if (half > r_dist) begin
            n_best = mid;
            n_dist = half;
        end
    end

    // Final pick: empty lot takes slot 1, a free tail may beat the best gap
    assign tail = eff_size - r_prev;
    always_comb begin
        if (r_prev == '0) begin
            pick = SLOT_W'(1);
        end else if (r_prev < eff_size && tail > r_dist) begin
            pick = eff_size;
        end else begin
            pick = r_best;
        end
    end

    // Memory write port selection
    always_comb begin
        occ_we    = 1'b0;
        occ_waddr = '0;
        occ_wdata = 1'b0;
        cli_we    = 1'b0;
        cli_waddr = id_addr;
        cli_wdata = '0;
        if (i_cmd.clr_en) begin
            occ_we    = 32'(r_clr_cnt) < NUM_SLOTS;
            occ_waddr = SLOT_AW'(r_clr_cnt);
            cli_we    = 32'(r_clr_cnt) < NUM_CLIENTS;
            cli_waddr = CLI_AW'(r_clr_cnt);
        end else if (i_cmd.leave_wr) begin
            occ_we    = r_held != '0;
            occ_waddr = SLOT_AW'(r_held - SLOT_W'(1));
            cli_we    = 1'b1;
        end else if (i_cmd.park_wr) begin
            occ_we    = 1'b1;
            occ_waddr = SLOT_AW'(pick - SLOT_W'(1));
            occ_wdata = 1'b1;
            cli_we    = 1'b1;
            cli_wdata = pick;
        end
    end

    always_ff @(posedge i_clk) begin
        if (occ_we) mem_occ[occ_waddr] <= occ_wdata;
        r_occ_rd <= mem_occ[SLOT_AW'(r_s - SLOT_W'(1))];
    end

    always_ff @(posedge i_clk) begin
        if (cli_we) mem_cli[cli_waddr] <= cli_wdata;
        r_held <= mem_cli[id_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lot_size  <= LOT_SIZE_RESET;
            r_clr_cnt   <= '0;
            r_rd_vld    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_lot_size <= i_cfg.lot_size;
            if (i_cmd.clr_en) r_clr_cnt <= CLR_W'(r_clr_cnt + 1'b1);
            r_rd_vld <= i_cmd.scan_issue;
            if (i_cmd.res_load) begin
                r_out_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_cmd.req_ready) begin
            r_cmd <= i_req.cmd;
            r_id  <= i_req.client_id;
        end
        if (i_cmd.scan_start) begin
            r_s    <= SLOT_W'(1);
            r_prev <= '0;
            r_best <= '0;
            r_dist <= '0;
        end else begin
            if (i_cmd.scan_issue) begin
                r_s       <= r_s + 1'b1;
                r_rd_slot <= r_s;
            end
            if (r_rd_vld && r_occ_rd) begin
                r_best <= n_best;
                r_dist <= n_dist;
                r_prev <= r_rd_slot;
            end
        end
        if (i_cmd.res_load) begin
            case (i_cmd.res_sel)
                RES_HELD: begin
                    r_out_slot <= SLOT_OUT_W'(r_held);
                    r_out_full <= 1'b0;
                end
                RES_PICK: begin
                    r_out_slot <= SLOT_OUT_W'(pick);
                    r_out_full <= pick == '0;
                end
                default: begin
                    r_out_slot <= '0;
                    r_out_full <= 1'b0;
                end
            endcase
        end
    end

    assign o_rsp.valid    = r_out_valid;
    assign o_rsp.slot     = r_out_slot;
    assign o_rsp.lot_full = r_out_full;

    always_comb begin
        o_stat.clr_last  = r_clr_cnt == CLR_W'(CLR_DEPTH - 1);
        o_stat.req_valid = i_req.valid;
        o_stat.is_leave  = r_cmd == CMD_LEAVE;
        o_stat.id_ok     = 32'(r_id) < NUM_CLIENTS;
        o_stat.held_nz   = r_held != '0;
        o_stat.scan_last = r_s == eff_size;
        o_stat.pick_nz   = pick != '0;
        o_stat.out_free  = !r_out_valid || o_rsp.ready;
    end

endmodule

`default_nettype wire
